/* rtl/core/mffu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback frame unwrap package
// Shared constants, register codes and structs for the frame unwrap block.
// ----------------------------------------------------------------------------
package mffu_pkg;

  localparam int unsigned TRACKED_MOTORS_DEF   = 2;
  localparam int unsigned MAX_PLAIN_MOTORS_DEF = 8;

  localparam int unsigned ID_W       = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned DELTA_W    = WORD_W + 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [ID_W-1:0]    PLAIN_FIRST_ID      = 11'h201;
  localparam logic [COUNT_W-1:0] PLAIN_COUNT_RESET   = 4'd4;
  localparam logic [ID_W-1:0]    TRACKED_BASE_RESET  = 11'd517;

  localparam logic signed [DELTA_W-1:0] HALF_TURN       = 18'sd4096;
  localparam logic signed [DELTA_W-1:0] COUNTS_PER_TURN = 18'sd8192;

  typedef enum logic {
    REG_PLAIN_COUNT  = 1'b0,
    REG_TRACKED_BASE = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [COUNT_W-1:0] plain_motor_count;
    logic [ID_W-1:0]    tracked_base_id;
  } cfg_t;

  typedef struct packed {
    logic              is_plain;
    logic [SLOT_W-1:0] plain_slot;
    logic              is_tracked;
    logic              tracked_slot;
  } match_t;

endpackage
`default_nettype wire

/* rtl/core/mffu_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame unwrap channel interfaces
// Valid/ready channels for feedback frames and decoded results.
// ----------------------------------------------------------------------------
interface mffu_frame_if;
  logic       valid;
  logic       ready;
  logic [10:0] frame_id;
  logic [7:0] angle_high;
  logic [7:0] angle_low;
  logic [7:0] speed_high;
  logic [7:0] speed_low;
  logic [7:0] current_high;
  logic [7:0] current_low;
  logic [7:0] temperature_in;

  modport source (
    output valid, frame_id, angle_high, angle_low, speed_high, speed_low,
           current_high, current_low, temperature_in,
    input  ready
  );
  modport sink (
    input  valid, frame_id, angle_high, angle_low, speed_high, speed_low,
           current_high, current_low, temperature_in,
    output ready
  );
endinterface

interface mffu_result_if;
  logic               valid;
  logic               ready;
  logic               is_plain;
  logic [2:0]         plain_slot;
  logic               is_tracked;
  logic               tracked_slot;
  logic [15:0]        angle_counts;
  logic signed [15:0] speed_value;
  logic signed [15:0] current_value;
  logic [7:0]         temperature_out;
  logic signed [31:0] total_counts;

  modport source (
    output valid, is_plain, plain_slot, is_tracked, tracked_slot, angle_counts,
           speed_value, current_value, temperature_out, total_counts,
    input  ready
  );
  modport sink (
    input  valid, is_plain, plain_slot, is_tracked, tracked_slot, angle_counts,
           speed_value, current_value, temperature_out, total_counts,
    output ready
  );
endinterface
`default_nettype wire

/* rtl/core/mffu_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame unwrap configuration registers
// APB-style register file holding the plain motor count and tracked base id.
// ----------------------------------------------------------------------------
module mffu_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mffu_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mffu_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mffu_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output mffu_pkg::cfg_t                       cfg
);
  import mffu_pkg::*;

  reg_sel_t sel;
  logic     wr_en;

  assign sel    = reg_sel_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plain_motor_count <= PLAIN_COUNT_RESET;
      cfg.tracked_base_id   <= TRACKED_BASE_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_PLAIN_COUNT:  cfg.plain_motor_count <= pwdata[COUNT_W-1:0];
        REG_TRACKED_BASE: cfg.tracked_base_id   <= pwdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PLAIN_COUNT:  prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, cfg.plain_motor_count};
      REG_TRACKED_BASE: prdata = {{(APB_DATA_W-ID_W){1'b0}}, cfg.tracked_base_id};
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/mffu_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Frame identifier decode
// Matches the identifier against the plain and tracked motor ranges.
// ----------------------------------------------------------------------------
module mffu_decode #(
  parameter int unsigned TRACKED_MOTORS   = mffu_pkg::TRACKED_MOTORS_DEF,
  parameter int unsigned MAX_PLAIN_MOTORS = mffu_pkg::MAX_PLAIN_MOTORS_DEF,
  parameter int unsigned IDX_W            = 1
) (
  input  wire logic [mffu_pkg::ID_W-1:0] frame_id,
  input  mffu_pkg::cfg_t                 cfg,
  output mffu_pkg::match_t               match,
  output logic      [IDX_W-1:0]          tracked_index
);
  import mffu_pkg::*;

  logic [ID_W-1:0] plain_off;
  logic [ID_W-1:0] tracked_off;
  logic            plain_hit;
  logic            tracked_hit;

  assign plain_off   = frame_id - PLAIN_FIRST_ID;
  assign tracked_off = frame_id - cfg.tracked_base_id;

  assign plain_hit = (frame_id >= PLAIN_FIRST_ID)
                  && (plain_off < {{(ID_W-COUNT_W){1'b0}}, cfg.plain_motor_count})
                  && (plain_off < ID_W'(MAX_PLAIN_MOTORS));

  assign tracked_hit = (frame_id >= cfg.tracked_base_id)
                    && (tracked_off < ID_W'(TRACKED_MOTORS));

  assign match.is_plain     = plain_hit;
  assign match.plain_slot   = plain_hit ? plain_off[SLOT_W-1:0] : '0;
  assign match.is_tracked   = tracked_hit;
  assign match.tracked_slot = tracked_hit ? tracked_off[0] : 1'b0;
  assign tracked_index      = tracked_off[IDX_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/mffu_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-turn angle tracker
// Keeps the last angle and the unwrapped multi-turn total of each tracked motor.
// ----------------------------------------------------------------------------
module mffu_track #(
  parameter int unsigned TRACKED_MOTORS = mffu_pkg::TRACKED_MOTORS_DEF,
  parameter int unsigned IDX_W          = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          update,
  input  wire logic        [IDX_W-1:0]       index,
  input  wire logic        [mffu_pkg::WORD_W-1:0] angle,
  output logic signed      [mffu_pkg::TOTAL_W-1:0] total_next
);
  import mffu_pkg::*;

  logic [TRACKED_MOTORS-1:0]         seen;
  logic [WORD_W-1:0]                 prev_angle [TRACKED_MOTORS];
  logic signed [TOTAL_W-1:0]         turn_total [TRACKED_MOTORS];

  logic [WORD_W-1:0]                 base_angle;
  logic signed [TOTAL_W-1:0]         base_total;
  logic signed [DELTA_W-1:0]         raw_delta;
  logic signed [DELTA_W-1:0]         delta;

  // A motor seen for the first time starts from its own angle and a zero total.
  always_comb begin
    base_angle = seen[index] ? prev_angle[index] : angle;
    base_total = seen[index] ? turn_total[index] : '0;
    raw_delta  = $signed({2'b00, angle}) - $signed({2'b00, base_angle});
    if (raw_delta > HALF_TURN) begin
      delta = raw_delta - COUNTS_PER_TURN;
    end else if (raw_delta < -HALF_TURN) begin
      delta = raw_delta + COUNTS_PER_TURN;
    end else begin
      delta = raw_delta;
    end
    total_next = base_total + {{(TOTAL_W-DELTA_W){delta[DELTA_W-1]}}, delta};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (update) begin
      seen[index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      prev_angle[index] <= angle;
      turn_total[index] <= total_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/motor_feedback_frame_unwrap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Motor feedback frame unwrap
// Decodes motor feedback frames and keeps multi-turn totals of tracked motors.
//
// Frames arrive on the valid/ready channel "frame"; each one yields exactly
// one transaction on the channel "result". A frame is captured in an input
// register, decoded and unwrapped in the following cycle, and the result is
// held in an output register. One frame is accepted every cycle while the
// receiver does not stall; frames for the same motor may follow each other
// directly, since the tracker state is written at the same edge that loads the
// result register. When the receiver stalls, the result register holds its
// transaction and the input register still takes one more frame before ready
// drops. Reset empties both registers, clears every tracked motor's first-frame
// flag and loads the register defaults (four plain motors, tracked base
// identifier 0x205). The APB port writes registers at byte addresses 0 and 4;
// the user must write it only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module motor_feedback_frame_unwrap #(
  parameter int unsigned TRACKED_MOTORS   = mffu_pkg::TRACKED_MOTORS_DEF,
  parameter int unsigned MAX_PLAIN_MOTORS = mffu_pkg::MAX_PLAIN_MOTORS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mffu_frame_if.sink                           frame,
  mffu_result_if.source                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mffu_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mffu_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mffu_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import mffu_pkg::*;

  localparam int unsigned IDX_W = (TRACKED_MOTORS > 1) ? $clog2(TRACKED_MOTORS) : 1;

  cfg_t                     cfg;
  match_t                   match;
  logic [IDX_W-1:0]         tracked_index;
  logic signed [TOTAL_W-1:0] total_next;

  logic                     s1_valid;
  logic [ID_W-1:0]          s1_id;
  logic [WORD_W-1:0]        s1_angle;
  logic [WORD_W-1:0]        s1_speed;
  logic [WORD_W-1:0]        s1_current;
  logic [BYTE_W-1:0]        s1_temp;

  logic                     s2_valid;
  logic                     advance;
  logic                     accept;

  assign advance     = s1_valid && (!s2_valid || result.ready);
  assign frame.ready = !s1_valid || advance;
  assign accept      = frame.valid && frame.ready;

  mffu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_id      <= frame.frame_id;
      s1_angle   <= {frame.angle_high, frame.angle_low};
      s1_speed   <= {frame.speed_high, frame.speed_low};
      s1_current <= {frame.current_high, frame.current_low};
      s1_temp    <= frame.temperature_in;
    end
  end

  mffu_decode #(
    .TRACKED_MOTORS   (TRACKED_MOTORS),
    .MAX_PLAIN_MOTORS (MAX_PLAIN_MOTORS),
    .IDX_W            (IDX_W)
  ) u_decode (
    .frame_id      (s1_id),
    .cfg           (cfg),
    .match         (match),
    .tracked_index (tracked_index)
  );

  mffu_track #(
    .TRACKED_MOTORS (TRACKED_MOTORS),
    .IDX_W          (IDX_W)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .update     (advance && match.is_tracked),
    .index      (tracked_index),
    .angle      (s1_angle),
    .total_next (total_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_valid || result.ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.is_plain        <= match.is_plain;
      result.plain_slot      <= match.plain_slot;
      result.is_tracked      <= match.is_tracked;
      result.tracked_slot    <= match.tracked_slot;
      result.angle_counts    <= s1_angle;
      result.speed_value     <= $signed(s1_speed);
      result.current_value   <= $signed(s1_current);
      result.temperature_out <= s1_temp;
      result.total_counts    <= match.is_tracked ? total_next : '0;
    end
  end

  assign result.valid = s2_valid;

endmodule
`default_nettype wire
